// File: design/ptsched_pkg.sv
// Shared constants for the priority thread scheduler: table sizes, command,
// slot-state and status codes.
// No dependencies.
package ptsched_pkg;

  localparam int SLOTS       = 4;
  localparam int PRIO_LEVELS = 3;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int PRIO_W = $clog2(PRIO_LEVELS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam int CMD_W    = 3;
  localparam int PRIO_IN_W = 2;
  localparam int STATUS_W = 2;
  localparam int FIELD_W  = 2;

  localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_YIELD   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_EXIT    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SETPRIO = 3'd4;

  localparam logic [1:0] ST_FREE     = 2'd0;
  localparam logic [1:0] ST_RUNNABLE = 2'd1;
  localparam logic [1:0] ST_RUNNING  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NONE = 2'd2;

endpackage

// File: design/priority_thread_scheduler_top.sv
// Priority thread scheduler: slot table, sequencer and a shared slot-scan unit.
// Depends on ptsched_pkg.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, cmd_i, prio_in_i   | input
//  out     | out_valid_o/out_ready_i, status_o,        | output
//          | new_slot_o, running_slot_o, old_prio_o,   |
//          | running_prio_o, all_exited_o              |
//
// Create, start, yield and an exit that reschedules scan one slot per cycle:
// accept, a scan step for every slot, write-back and result load, in that order.
// Set-priority, unknown commands and exits without a scan go from accept to result load.
// The slot scan is the single compare unit.
// Reset clears the whole table at once; no clearing pass is needed.
// A stalled result holds in the output register; the next word is taken
// only once the sequencer is back in idle.
module priority_thread_scheduler_top
  import ptsched_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CMD_W-1:0]      cmd_i,
  input  logic [PRIO_IN_W-1:0]  prio_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [FIELD_W-1:0]    new_slot_o,
  output logic [FIELD_W-1:0]    running_slot_o,
  output logic [FIELD_W-1:0]    old_prio_o,
  output logic [FIELD_W-1:0]    running_prio_o,
  output logic                  all_exited_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WB   = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [SLOT_W-1:0] IDX_LAST = SLOT_W'(SLOTS - 1);

  logic [1:0]        fsm_q;
  logic [1:0]        slot_state_q [SLOTS];
  logic [PRIO_W-1:0] slot_prio_q  [SLOTS];
  logic [SLOT_W-1:0] cur_idx_q;
  logic              cur_valid_q;
  logic [CNT_W-1:0]  live_q;

  logic [CMD_W-1:0]    cmd_q;
  logic [PRIO_W-1:0]   prio_q;
  logic [SLOT_W-1:0]   idx_q;
  logic [SLOT_W-1:0]   best_idx_q;
  logic [PRIO_W-1:0]   best_prio_q;
  logic                found_q;
  logic [STATUS_W-1:0] status_q;
  logic [FIELD_W-1:0]  new_slot_q;
  logic [FIELD_W-1:0]  old_prio_q;
  logic                all_exited_q;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [FIELD_W-1:0]  out_new_slot_q;
  logic [FIELD_W-1:0]  out_run_slot_q;
  logic [FIELD_W-1:0]  out_old_prio_q;
  logic [FIELD_W-1:0]  out_run_prio_q;
  logic                out_all_exited_q;

  logic [PRIO_W-1:0] prio_clamp;
  logic [CNT_W-1:0]  live_dec;
  logic [1:0]        scan_state;
  logic [PRIO_W-1:0] scan_prio;
  logic              hit_free;
  logic              hit_run;
  logic              out_load;

  // saturate out-of-range priorities to the top level
  assign prio_clamp = (int'(prio_in_i) >= PRIO_LEVELS) ? PRIO_W'(PRIO_LEVELS - 1)
                                                       : PRIO_W'(prio_in_i);
  assign live_dec   = (live_q != '0) ? live_q - CNT_W'(1) : '0;

  // shared scan unit: one slot per cycle
  assign scan_state = slot_state_q[idx_q];
  assign scan_prio  = slot_prio_q[idx_q];
  assign hit_free   = (scan_state == ST_FREE);
  assign hit_run    = (scan_state == ST_RUNNABLE) && (scan_prio >= best_prio_q);

  assign in_ready_o = (fsm_q == S_IDLE);
  assign out_load   = (fsm_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q        <= S_IDLE;
      for (int i = 0; i < SLOTS; i++) begin
        slot_state_q[i] <= ST_FREE;
        slot_prio_q[i]  <= '0;
      end
      cur_idx_q    <= '0;
      cur_valid_q  <= 1'b0;
      live_q       <= '0;
      cmd_q        <= '0;
      prio_q       <= '0;
      idx_q        <= '0;
      best_idx_q   <= '0;
      best_prio_q  <= '0;
      found_q      <= 1'b0;
      status_q     <= STAT_OK;
      new_slot_q   <= '0;
      old_prio_q   <= '0;
      all_exited_q <= 1'b0;
      out_valid_q      <= 1'b0;
      out_status_q     <= STAT_OK;
      out_new_slot_q   <= '0;
      out_run_slot_q   <= '0;
      out_old_prio_q   <= '0;
      out_run_prio_q   <= '0;
      out_all_exited_q <= 1'b0;
    end else begin
      if (out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (fsm_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q        <= cmd_i;
            prio_q       <= prio_clamp;
            status_q     <= STAT_OK;
            new_slot_q   <= '0;
            old_prio_q   <= '0;
            all_exited_q <= 1'b0;
            idx_q        <= '0;
            best_idx_q   <= '0;
            best_prio_q  <= '0;
            found_q      <= 1'b0;
            case (cmd_i)
              CMD_CREATE: begin
                fsm_q <= S_SCAN;
              end
              CMD_START, CMD_YIELD: begin
                // return the running slot to the pool before the scan
                if (cur_valid_q) begin
                  slot_state_q[cur_idx_q] <= ST_RUNNABLE;
                end
                fsm_q <= S_SCAN;
              end
              CMD_EXIT: begin
                if (!cur_valid_q) begin
                  status_q <= STAT_NONE;
                  fsm_q    <= S_DONE;
                end else begin
                  slot_state_q[cur_idx_q] <= ST_FREE;
                  slot_prio_q[cur_idx_q]  <= '0;
                  live_q <= live_dec;
                  if (live_dec == '0) begin
                    cur_valid_q  <= 1'b0;
                    cur_idx_q    <= '0;
                    all_exited_q <= 1'b1;
                    fsm_q        <= S_DONE;
                  end else begin
                    fsm_q <= S_SCAN;
                  end
                end
              end
              CMD_SETPRIO: begin
                if (!cur_valid_q) begin
                  status_q <= STAT_NONE;
                end else begin
                  old_prio_q <= FIELD_W'(slot_prio_q[cur_idx_q]);
                  slot_prio_q[cur_idx_q] <= prio_clamp;
                end
                fsm_q <= S_DONE;
              end
              default: begin
                fsm_q <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (cmd_q == CMD_CREATE) begin
            // keep the lowest free slot
            if (!found_q && hit_free) begin
              found_q    <= 1'b1;
              best_idx_q <= idx_q;
            end
          end else if (hit_run) begin
            // ">=" lets a later slot of equal priority win
            found_q     <= 1'b1;
            best_idx_q  <= idx_q;
            best_prio_q <= scan_prio;
          end
          if (idx_q == IDX_LAST) begin
            fsm_q <= S_WB;
          end else begin
            idx_q <= idx_q + SLOT_W'(1);
          end
        end
        S_WB: begin
          if (cmd_q == CMD_CREATE) begin
            if (found_q) begin
              slot_state_q[best_idx_q] <= ST_RUNNABLE;
              slot_prio_q[best_idx_q]  <= prio_q;
              live_q     <= live_q + CNT_W'(1);
              new_slot_q <= FIELD_W'(best_idx_q);
            end else begin
              status_q <= STAT_FULL;
            end
          end else if (found_q) begin
            cur_idx_q   <= best_idx_q;
            cur_valid_q <= 1'b1;
            slot_state_q[best_idx_q] <= ST_RUNNING;
          end else begin
            cur_idx_q   <= '0;
            cur_valid_q <= 1'b0;
            status_q    <= STAT_NONE;
          end
          fsm_q <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_load) begin
            out_valid_q      <= 1'b1;
            out_status_q     <= status_q;
            out_new_slot_q   <= new_slot_q;
            out_old_prio_q   <= old_prio_q;
            out_all_exited_q <= all_exited_q;
            out_run_slot_q   <= cur_valid_q ? FIELD_W'(cur_idx_q) : '0;
            out_run_prio_q   <= cur_valid_q ? FIELD_W'(slot_prio_q[cur_idx_q]) : '0;
            fsm_q            <= S_IDLE;
          end
        end
        default: begin
          fsm_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign new_slot_o     = out_new_slot_q;
  assign running_slot_o = out_run_slot_q;
  assign old_prio_o     = out_old_prio_q;
  assign running_prio_o = out_run_prio_q;
  assign all_exited_o   = out_all_exited_q;

endmodule

// File: design/ptsched_checker.sv
// Port-level checks for the priority thread scheduler, bound to its top level.
// Depends on ptsched_pkg and priority_thread_scheduler_top.
module ptsched_checker
  import ptsched_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [STATUS_W-1:0]  status_o,
  input logic [FIELD_W-1:0]   new_slot_o,
  input logic [FIELD_W-1:0]   running_slot_o,
  input logic [FIELD_W-1:0]   running_prio_o,
  input logic                 all_exited_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(running_slot_o))
    else $error("stalled result word changed");

  // one word in flight: no accept right after an accept
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // last exit leaves nothing running
  a_last_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && all_exited_o |-> status_o == STAT_OK && running_slot_o == '0
      && running_prio_o == '0)
    else $error("all_exited with a running thread");

  // failed create reports slot zero
  a_full_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_FULL |-> new_slot_o == '0 && !all_exited_o)
    else $error("table full with a claimed slot");

endmodule

bind priority_thread_scheduler_top ptsched_checker u_ptsched_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .new_slot_o     (new_slot_o),
  .running_slot_o (running_slot_o),
  .running_prio_o (running_prio_o),
  .all_exited_o   (all_exited_o)
);
